FILE: hw/rtl/vbr_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// vbr_pkg: shared types and constants of the velocity brightness ramp
// Item formats, configuration register indexes and reset values.
// ============================================================================
package vbr_pkg;

   // Default parameter values for the top level.
   localparam int TIME_BITS_DEFAULT = 32;
   localparam int FRAC_BITS_DEFAULT = 16;

   // Number of quotient bits of the ramp division (the offset is one level).
   localparam int RAMP_Q_BITS = 8;

   // Configuration register indexes.
   localparam logic [1:0] CSR_MIN_LEVEL  = 2'd0;
   localparam logic [1:0] CSR_MAX_LEVEL  = 2'd1;
   localparam logic [1:0] CSR_FULL_SPEED = 2'd2;
   localparam logic [1:0] CSR_RAMP_MS    = 2'd3;

   // Configuration reset values.
   localparam logic [7:0]  MIN_LEVEL_RESET  = 8'd50;
   localparam logic [7:0]  MAX_LEVEL_RESET  = 8'd240;
   localparam logic [15:0] FULL_SPEED_RESET = 16'd800;
   localparam logic [15:0] RAMP_MS_RESET    = 16'd200;

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [15:0] speed;
      logic [7:0]  current_level;
      logic [31:0] now_ms;
      logic        first_pass;
   } vbr_req_type;

   typedef struct packed {
      logic [7:0] level_out;
      logic [7:0] target_out;
   } vbr_rsp_type;

   typedef struct packed {
      logic [7:0]  min_level;
      logic [7:0]  max_level;
      logic [15:0] full_speed;
      logic [15:0] ramp_ms;
   } vbr_cfg_type;

   // An item after classification by the front.
   typedef struct packed {
      vbr_req_type req;
      logic        saturated;
      logic        span_neg;
      logic [7:0]  span_mag;
   } vbr_work_type;

   // Head of the queue as seen by the back.
   typedef struct packed {
      logic         valid;
      vbr_work_type work;
   } vbr_head_type;

endpackage

FILE: hw/rtl/vbr_front.sv
`timescale 1ns / 1ps
// ============================================================================
// vbr_front: input acceptance and classification
// Accepts items while the queue has room and tags each one with its
// saturation flag and the sign and magnitude of the level span.
// ============================================================================
module vbr_front (
   input  vbr_pkg::vbr_req_type  req_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  vbr_pkg::vbr_cfg_type  cfg,
   input  logic                  queue_full,
   output logic                  push,
   output vbr_pkg::vbr_work_type push_work
);
   import vbr_pkg::*;

   logic span_neg;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;
   assign span_neg  = cfg.max_level < cfg.min_level;

   always_comb begin
      push_work.req       = req_data;
      // A zero full speed saturates every item, which matches the compare.
      push_work.saturated = req_data.speed >= cfg.full_speed;
      push_work.span_neg  = span_neg;
      push_work.span_mag  = span_neg ? cfg.min_level - cfg.max_level
                                     : cfg.max_level - cfg.min_level;
   end

endmodule

FILE: hw/rtl/vbr_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// vbr_queue: short queue between the front and the back
// A small circular buffer of classified items.
// ============================================================================
module vbr_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  vbr_pkg::vbr_work_type push_work,
   input  logic                  pop,
   output vbr_pkg::vbr_head_type head,
   output logic                  full
);
   import vbr_pkg::*;

   vbr_work_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]         count_ff, count_in;

   assign full       = count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
   assign head.valid = count_ff != '0;
   assign head.work  = entry_ff[rd_ptr_ff];

   function automatic logic [QUEUE_PTR_W-1:0] next_ptr(input logic [QUEUE_PTR_W-1:0] p);
      next_ptr = (p == QUEUE_PTR_W'(QUEUE_DEPTH-1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_work;
      end
   end

endmodule

FILE: hw/rtl/vbr_back.sv
`timescale 1ns / 1ps
// ============================================================================
// vbr_back: target and ramp computation
// Sequencer around one shared bit-serial divider and a multiplier step;
// holds the ramp state and the result register.
// ============================================================================
module vbr_back #(
   parameter int TIME_BITS = vbr_pkg::TIME_BITS_DEFAULT,
   parameter int FRAC_BITS = vbr_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  vbr_pkg::vbr_cfg_type  cfg,
   input  vbr_pkg::vbr_head_type head,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output vbr_pkg::vbr_rsp_type  rsp_data
);
   import vbr_pkg::*;

   localparam int CNT_W = $clog2(FRAC_BITS);
   localparam int NUM_W = 25;
   localparam logic [FRAC_BITS+8:0] HALF = (FRAC_BITS+9)'(1) << (FRAC_BITS-1);

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_DIV  = 9'b000000010,
      S_SQR  = 9'b000000100,
      S_CUBE = 9'b000001000,
      S_TGT  = 9'b000010000,
      S_UPD  = 9'b000100000,
      S_CHK  = 9'b001000000,
      S_RDIV = 9'b010000000,
      S_DONE = 9'b100000000
   } vbr_state_type;

   vbr_state_type          state_ff, state_in;
   vbr_work_type           work_ff, work_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [17:0]            rem_ff, rem_in;
   logic [7:0]             low_ff, low_in;
   logic [FRAC_BITS-1:0]   q_ff, q_in;
   logic [FRAC_BITS-1:0]   pw_ff, pw_in;
   logic [7:0]             target_ff, target_in;
   logic [7:0]             result_ff, result_in;
   logic                   ramp_neg_ff, ramp_neg_in;
   logic [7:0]             held_ff, held_in;
   logic [7:0]             start_lvl_ff, start_lvl_in;
   logic [TIME_BITS-1:0]   start_time_ff, start_time_in;
   logic [TIME_BITS-1:0]   elapsed_ff, elapsed_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   vbr_rsp_type            rsp_data_ff, rsp_data_in;

   logic [17:0]            div_shift, div_den, div_rem;
   logic                   div_ge;
   logic [2*FRAC_BITS-1:0] sq_prod;
   logic [FRAC_BITS+7:0]   tgt_prod;
   logic [FRAC_BITS+8:0]   tgt_sum;
   logic [7:0]             tgt_off;
   logic [63:0]            now_wide;
   logic [TIME_BITS-1:0]   now_t;
   logic                   restart;
   logic [7:0]             ramp_mag;
   logic                   ramp_neg;
   logic [23:0]            ramp_prod;
   logic [NUM_W-1:0]       ramp_num;
   logic                   rsp_take;
   logic                   rsp_load;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign rsp_load  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_take);
   assign pop       = (state_ff == S_IDLE) && head.valid;

   assign now_wide  = {32'b0, work_ff.req.now_ms};
   assign now_t     = now_wide[TIME_BITS-1:0];

   always_comb begin
      // Shared restoring divider step: speed fraction or ramp offset.
      div_shift = {rem_ff[16:0], (state_ff == S_RDIV) ? low_ff[7] : 1'b0};
      div_den   = (state_ff == S_RDIV) ? {1'b0, cfg.ramp_ms, 1'b0}
                                       : {2'b0, cfg.full_speed};
      div_ge    = div_shift >= div_den;
      div_rem   = div_ge ? div_shift - div_den : div_shift;

      sq_prod   = {{FRAC_BITS{1'b0}}, (state_ff == S_SQR) ? q_ff : pw_ff}
                * {{FRAC_BITS{1'b0}}, q_ff};
      tgt_prod  = {8'b0, pw_ff} * {{FRAC_BITS{1'b0}}, work_ff.span_mag};
      tgt_sum   = {1'b0, tgt_prod} + HALF;
      tgt_off   = tgt_sum[FRAC_BITS+7:FRAC_BITS];

      restart   = !work_ff.req.first_pass && (held_ff != target_ff)
                && (start_lvl_ff != work_ff.req.current_level);

      ramp_neg  = target_ff < start_lvl_ff;
      ramp_mag  = ramp_neg ? start_lvl_ff - target_ff : target_ff - start_lvl_ff;
      ramp_prod = {8'b0, elapsed_ff[15:0]} * {16'b0, ramp_mag};
      ramp_num  = {ramp_prod, 1'b0} + {9'b0, cfg.ramp_ms};
   end

   always_comb begin
      state_in      = state_ff;
      work_in       = work_ff;
      cnt_in        = cnt_ff;
      rem_in        = rem_ff;
      low_in        = low_ff;
      q_in          = q_ff;
      pw_in         = pw_ff;
      target_in     = target_ff;
      result_in     = result_ff;
      ramp_neg_in   = ramp_neg_ff;
      held_in       = held_ff;
      start_lvl_in  = start_lvl_ff;
      start_time_in = start_time_ff;
      elapsed_in    = elapsed_ff;
      rsp_valid_in  = rsp_take ? 1'b0 : rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               work_in   = head.work;
               target_in = cfg.max_level;
               rem_in    = {2'b0, head.work.req.speed};
               q_in      = '0;
               cnt_in    = CNT_W'(FRAC_BITS-1);
               state_in  = head.work.saturated ? S_UPD : S_DIV;
            end
         end
         S_DIV: begin
            rem_in = div_rem;
            q_in   = {q_ff[FRAC_BITS-2:0], div_ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_SQR;
            end
         end
         S_SQR: begin
            pw_in    = sq_prod[2*FRAC_BITS-1:FRAC_BITS];
            state_in = S_CUBE;
         end
         S_CUBE: begin
            pw_in    = sq_prod[2*FRAC_BITS-1:FRAC_BITS];
            state_in = S_TGT;
         end
         S_TGT: begin
            target_in = work_ff.span_neg ? cfg.min_level - tgt_off
                                         : cfg.min_level + tgt_off;
            state_in  = S_UPD;
         end
         S_UPD: begin
            held_in = target_ff;
            if (restart) begin
               start_lvl_in  = work_ff.req.current_level;
               start_time_in = now_t;
               elapsed_in    = '0;
            end else begin
               elapsed_in    = now_t - start_time_ff;
            end
            state_in = S_CHK;
         end
         S_CHK: begin
            result_in   = target_ff;
            ramp_neg_in = ramp_neg;
            rem_in      = {1'b0, ramp_num[NUM_W-1:RAMP_Q_BITS]};
            low_in      = ramp_num[RAMP_Q_BITS-1:0];
            q_in        = '0;
            cnt_in      = CNT_W'(RAMP_Q_BITS-1);
            if (work_ff.req.current_level == target_ff || cfg.ramp_ms == '0
                || elapsed_ff > TIME_BITS'(cfg.ramp_ms)) begin
               state_in = S_DONE;
            end else begin
               state_in = S_RDIV;
            end
         end
         S_RDIV: begin
            rem_in = div_rem;
            low_in = {low_ff[6:0], 1'b0};
            q_in   = {q_ff[FRAC_BITS-2:0], div_ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               result_in = ramp_neg_ff ? start_lvl_ff - q_in[7:0]
                                       : start_lvl_ff + q_in[7:0];
               state_in  = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.level_out  = result_ff;
               rsp_data_in.target_out = target_ff;
               state_in               = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         held_ff       <= '0;
         start_lvl_ff  <= '0;
         start_time_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         held_ff       <= held_in;
         start_lvl_ff  <= start_lvl_in;
         start_time_ff <= start_time_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      work_ff     <= work_in;
      cnt_ff      <= cnt_in;
      rem_ff      <= rem_in;
      low_ff      <= low_in;
      q_ff        <= q_in;
      pw_ff       <= pw_in;
      target_ff   <= target_in;
      result_ff   <= result_in;
      ramp_neg_ff <= ramp_neg_in;
      elapsed_ff  <= elapsed_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

FILE: hw/rtl/velocity_brightness_ramp_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// velocity_brightness_ramp_unit: speed to brightness mapping with ramping
// Maps a rotation speed to a target LED level through a cubic curve and
// ramps the applied level linearly toward it over a set time.
// ============================================================================
//
// Channel  Direction  Handshake              Payload
// -------  ---------  ---------------------  -------------------------------
// req      in         req_valid / req_stall  speed, current_level, now_ms,
//                                            first_pass
// rsp      out        rsp_valid / rsp_stall  level_out, target_out
// csr      in         csr_we                 csr_index, csr_wdata
//
// A ramping item below full speed keeps the back busy through the bit-serial
// divider that forms the speed fraction, the squaring and cubing steps, the
// target step, the ramp update and check, and the ramp division. A saturated
// item skips the fraction and the curve; an item that needs no ramp division
// skips it.
// Reset is synchronous and restores the configuration defaults and clears
// the ramp state; it needs no clearing pass.
// The front keeps accepting items into a two-entry queue while the back
// works or its result waits on rsp_stall, so each side stalls on its own.
//
module velocity_brightness_ramp_unit #(
   parameter int TIME_BITS = vbr_pkg::TIME_BITS_DEFAULT,
   parameter int FRAC_BITS = vbr_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  vbr_pkg::vbr_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output vbr_pkg::vbr_rsp_type rsp_data,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_wdata
);
   import vbr_pkg::*;

   // Configuration registers. The user must write them only while the block is
   // idle (the block does not enforce it), so the front and the back read them directly.
   vbr_cfg_type  cfg_ff, cfg_in;

   logic         queue_full;
   logic         push;
   vbr_work_type push_work;
   logic         pop;
   vbr_head_type head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_LEVEL:  cfg_in.min_level  = csr_wdata[7:0];
            CSR_MAX_LEVEL:  cfg_in.max_level  = csr_wdata[7:0];
            CSR_FULL_SPEED: cfg_in.full_speed = csr_wdata;
            CSR_RAMP_MS:    cfg_in.ramp_ms    = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_level  <= MIN_LEVEL_RESET;
         cfg_ff.max_level  <= MAX_LEVEL_RESET;
         cfg_ff.full_speed <= FULL_SPEED_RESET;
         cfg_ff.ramp_ms    <= RAMP_MS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front classifies each item as it is accepted.
   vbr_front u_front (
      .req_data   (req_data),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .push       (push),
      .push_work  (push_work)
   );

   vbr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_work (push_work),
      .pop       (pop),
      .head      (head),
      .full      (queue_full)
   );

   // The back computes the target, updates the ramp state and holds the
   // result register.
   vbr_back #(
      .TIME_BITS (TIME_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: sim/tb_velocity_brightness_ramp_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_velocity_brightness_ramp_unit: self-checking bench for the ramp unit
// Drives speed items through the req channel and checks every rsp item
// against an in-bench prediction of the target curve and the linear ramp.
// ============================================================================
module tb_velocity_brightness_ramp_unit;
   import vbr_pkg::*;

   localparam int FRAC = FRAC_BITS_DEFAULT;
   // The drain covers the two-entry queue and the item in the back with room
   // to spare.
   localparam int DRAIN_CYCLES = 128;
   // The longest correct stretch without a handshake is the long receiver
   // hold plus a few item times, so this is several times over that.
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int LONG_HOLD_CYCLES = 400;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   vbr_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   vbr_rsp_type rsp_data;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_MIN_LEVEL;
   logic [15:0] csr_wdata = '0;

   velocity_brightness_ramp_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Shadow copy of the configuration registers. It is updated when a write
   // is issued, which is safe because writes only happen while the unit is
   // idle.
   logic [7:0]  cfg_min  = MIN_LEVEL_RESET;
   logic [7:0]  cfg_max  = MAX_LEVEL_RESET;
   logic [15:0] cfg_full = FULL_SPEED_RESET;
   logic [15:0] cfg_ramp = RAMP_MS_RESET;

   // Ramp state as the unit should hold it after each accepted item.
   logic [7:0]  held_tgt  = '0;
   logic [7:0]  start_lvl = '0;
   logic [31:0] start_ms  = '0;

   vbr_req_type speed_items[$];      // items waiting to be offered
   vbr_rsp_type expected_levels[$];  // predicted results, oldest first
   int          errors = 0;
   int          idle_cycles = 0;

   // State of the well-formed item generator, carried across phases so the
   // time base keeps running like a real frame loop.
   logic [31:0] gen_now   = 32'd1000;
   logic [15:0] gen_speed = '0;
   logic [7:0]  gen_level = 8'd50;

   // Target level for a speed: a cubic curve from min to max below full
   // speed, and max at or above it. A full speed of zero always saturates.
   function automatic logic [7:0] level_target(input logic [15:0] spd);
      logic [63:0] mag;
      logic [63:0] frac;
      logic [63:0] frac2;
      logic [63:0] frac3;
      logic [63:0] offs;
      logic        down;
      if (spd >= cfg_full) begin
         return cfg_max;
      end
      down  = cfg_max < cfg_min;
      mag   = {56'd0, down ? cfg_min - cfg_max : cfg_max - cfg_min};
      frac  = ({48'd0, spd} << FRAC) / {48'd0, cfg_full};
      frac2 = (frac * frac) >> FRAC;
      frac3 = (frac2 * frac) >> FRAC;
      offs  = (frac3 * mag + (64'd1 << (FRAC - 1))) >> FRAC;
      return down ? cfg_min - offs[7:0] : cfg_min + offs[7:0];
   endfunction

   // Advances the ramp state by one item and returns the level to apply.
   task automatic compute_level(input vbr_req_type it, output vbr_rsp_type res);
      logic [7:0]  tgt;
      logic [7:0]  lvl;
      logic [7:0]  mag;
      logic [7:0]  offs;
      logic [31:0] elapsed;
      logic [63:0] num;
      logic [63:0] den;
      tgt = level_target(it.speed);
      lvl = it.current_level;
      // A first pass snaps to the target; the ramp rule below may still
      // override that when the shown level differs from it.
      if (it.first_pass) begin
         held_tgt = tgt;
         lvl = tgt;
      end
      // A new target restarts the ramp from the shown level, but only when
      // that level moved away from the previous start level.
      if (held_tgt != tgt) begin
         held_tgt = tgt;
         if (start_lvl != it.current_level) begin
            start_lvl = it.current_level;
            start_ms  = it.now_ms;
         end
      end
      if (it.current_level != held_tgt) begin
         // Elapsed time wraps with the 32-bit millisecond counter.
         elapsed = it.now_ms - start_ms;
         if (cfg_ramp == 16'd0 || elapsed > {16'd0, cfg_ramp}) begin
            lvl = held_tgt;
         end else begin
            mag  = (held_tgt < start_lvl) ? start_lvl - held_tgt : held_tgt - start_lvl;
            num  = 64'd2 * {32'd0, elapsed} * {56'd0, mag} + {48'd0, cfg_ramp};
            den  = 64'd2 * {48'd0, cfg_ramp};
            offs = 8'(num / den);
            lvl  = (held_tgt < start_lvl) ? start_lvl - offs : start_lvl + offs;
         end
      end
      res.level_out  = lvl;
      res.target_out = tgt;
   endtask

   // ------------------------------------------------------------------------
   // Driver. Items leave the queue in bursts of random length separated by
   // random gaps; about a third of the bursts have no gap after them. A
   // stalled item is held unchanged until it is accepted, and prediction
   // happens at the edge where the item is accepted.
   // ------------------------------------------------------------------------
   int          burst_left = 0;
   int          gap_left = 0;
   vbr_rsp_type predicted;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         held_tgt  = '0;
         start_lvl = '0;
         start_ms  = '0;
      end else begin
         if (req_valid && !req_stall) begin
            compute_level(req_data, predicted);
            expected_levels.push_back(predicted);
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (speed_items.size() > 0) begin
               req_valid <= 1'b1;
               req_data  <= speed_items.pop_front();
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 40);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver stall pattern. The mode changes at random intervals, so stalls
   // land on every phase of an item's processing. Once, when plenty of items
   // are queued up, the receiver holds off for a long stretch so the unit
   // fills up and has to stall its input.
   // ------------------------------------------------------------------------
   int             hold_left = 0;
   bit             long_hold_done = 1'b0;
   stall_mode_type stall_mode = STALL_NONE;
   int             mode_cycles = 0;

   always @(posedge clock) begin
      if (!reset && !long_hold_done && speed_items.size() > 100) begin
         long_hold_done = 1'b1;
         hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_cycles == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_cycles = $urandom_range(20, 150);
         end
         mode_cycles--;
         case (stall_mode)
            STALL_NONE: begin
               rsp_stall <= 1'b0;
            end
            STALL_LIGHT: begin
               rsp_stall <= ($urandom_range(0, 3) == 0);
            end
            STALL_HEAVY: begin
               rsp_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
               rsp_stall <= (mode_cycles % 5 < 2);
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Monitor. Every accepted result is checked field by field against the
   // oldest prediction.
   // ------------------------------------------------------------------------
   vbr_rsp_type want;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_levels.size() == 0) begin
            errors++;
            $display("%0t unexpected item: expected none, actual level_out %0d target_out %0d",
                     $time, rsp_data.level_out, rsp_data.target_out);
         end else begin
            want = expected_levels.pop_front();
            if (rsp_data.level_out !== want.level_out) begin
               errors++;
               $display("%0t level_out mismatch: expected %0d, actual %0d",
                        $time, want.level_out, rsp_data.level_out);
            end
            if (rsp_data.target_out !== want.target_out) begin
               errors++;
               $display("%0t target_out mismatch: expected %0d, actual %0d",
                        $time, want.target_out, rsp_data.target_out);
            end
         end
      end
   end

   // Watchdog: ends the run when no item moves on either channel for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t watchdog: no item moved for %0d cycles", $time, idle_cycles);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------------
   task automatic add_item(input logic [15:0] spd, input logic [7:0] lvl,
                           input logic [31:0] now, input logic first);
      vbr_req_type it;
      it.speed         = spd;
      it.current_level = lvl;
      it.now_ms        = now;
      it.first_pass    = first;
      speed_items.push_back(it);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_MIN_LEVEL:  cfg_min  = value[7:0];
         CSR_MAX_LEVEL:  cfg_max  = value[7:0];
         CSR_FULL_SPEED: cfg_full = value;
         default:        cfg_ramp = value;
      endcase
   endtask

   task automatic set_config(input logic [7:0] lo, input logic [7:0] hi,
                             input logic [15:0] full, input logic [15:0] ramp);
      write_reg(CSR_MIN_LEVEL, {8'd0, lo});
      write_reg(CSR_MAX_LEVEL, {8'd0, hi});
      write_reg(CSR_FULL_SPEED, full);
      write_reg(CSR_RAMP_MS, ramp);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Waits until every queued item was accepted and every result came back.
   task automatic wait_idle();
      while (speed_items.size() != 0 || req_valid) @(posedge clock);
      while (expected_levels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_speed();
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return cfg_full;
         2: return cfg_full - 16'd1;
         3: return 16'hFFFF;
         4: return 16'($urandom_range(0, cfg_full));
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // Mostly frame-loop sequences: time moves in steps up to about a third of
   // the ramp length, the speed holds for a while and then jumps, and the shown
   // level follows the target loosely. About one item in eight is noise.
   task automatic add_random(input int count);
      logic [7:0] tgt;
      int         i;
      for (i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 12) begin
            add_item(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)), $urandom,
                     1'($urandom_range(0, 1)));
         end else begin
            if ($urandom_range(0, 5) == 0) begin
               gen_speed = pick_speed();
            end
            case ($urandom_range(0, 15))
               0: gen_now = 32'hFFFF_FFFF - $urandom_range(0, 2 * cfg_ramp + 4);
               1: gen_now = $urandom;
               default: gen_now = gen_now + $urandom_range(0, cfg_ramp / 3 + 2);
            endcase
            tgt = level_target(gen_speed);
            case ($urandom_range(0, 3))
               0: gen_level = tgt;
               1: gen_level = gen_level;
               2: gen_level = 8'((int'(gen_level) + int'(tgt)) / 2);
               default: gen_level = 8'($urandom_range(0, 255));
            endcase
            add_item(gen_speed, gen_level, gen_now, $urandom_range(0, 24) == 0);
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Test sequence. Each phase sets a configuration while the unit is idle,
   // queues its items and drains completely before the next phase; that
   // drain is also where the sender pauses until every result is back.
   // ------------------------------------------------------------------------
   int k;

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset configuration: min 50, max 240, full speed 800, ramp 200 ms.
      add_item(16'd0, 8'd0, 32'd0, 1'b1);                 // first pass at zero speed
      add_item(16'd400, 8'd50, 32'd10, 1'b0);             // new target starts a ramp
      add_item(16'd400, 8'd60, 32'd110, 1'b0);            // halfway through the ramp
      add_item(16'd400, 8'd70, 32'd211, 1'b0);            // ramp time has passed
      add_item(16'd400, 8'd74, 32'd300, 1'b0);            // level already at target
      add_item(16'd800, 8'd74, 32'd310, 1'b0);            // exactly full speed
      add_item(16'd799, 8'd255, 32'hFFFF_FFF0, 1'b0);     // just below full speed
      add_item(16'hFFFF, 8'd0, 32'hFFFF_FFFF, 1'b0);      // largest speed
      add_item(16'd1, 8'd240, 32'h0000_0040, 1'b0);       // time has wrapped; new target restarts the ramp
      add_item(16'hFFFF, 8'd0, 32'h0000_0100, 1'b1);      // first pass, level differs
      add_item(16'hFFFF, 8'd240, 32'h0000_0200, 1'b1);    // first pass, level matches
      add_item(16'd0, 8'd255, 32'h8000_0000, 1'b0);
      add_item(16'd0, 8'd128, 32'h8000_00C8, 1'b0);
      add_item(16'd0, 8'd128, 32'h8000_00C9, 1'b0);
      wait_idle();
      add_random(200);
      wait_idle();

      // Widest span with the slowest curve and the longest ramp.
      set_config(8'd0, 8'd255, 16'hFFFF, 16'hFFFF);
      add_item(16'hFFFE, 8'd0, 32'd0, 1'b0);
      add_item(16'hFFFF, 8'd0, 32'd1, 1'b0);
      add_random(150);
      wait_idle();

      // Max below min, so the curve falls, with the shortest ramp.
      set_config(8'd255, 8'd0, 16'd1, 16'd1);
      add_item(16'd0, 8'd100, 32'd5, 1'b0);
      add_item(16'd0, 8'd100, 32'd6, 1'b0);
      add_random(150);
      wait_idle();

      // Zero full speed always saturates; zero ramp time jumps to the target.
      set_config(8'd10, 8'd200, 16'd0, 16'd0);
      add_item(16'd0, 8'd0, 32'd5, 1'b0);
      add_item(16'hFFFF, 8'd7, 32'd6, 1'b0);
      add_item(16'd0, 8'd200, 32'd7, 1'b1);
      add_random(100);
      wait_idle();

      // Random settings with short ramps so the ramp end is reached often.
      for (k = 0; k < 5; k++) begin
         set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    16'(($urandom_range(0, 1) == 0) ? $urandom_range(1, 2000)
                                                    : $urandom_range(1, 65535)),
                    16'($urandom_range(1, 400)));
         add_random(120);
         wait_idle();
      end

      // No span at all: every speed gives the same target.
      set_config(8'd128, 8'd128, 16'd300, 16'd50);
      add_random(100);
      wait_idle();

      if (errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/vbr_pkg.sv
hw/rtl/vbr_front.sv
hw/rtl/vbr_queue.sv
hw/rtl/vbr_back.sv
hw/rtl/velocity_brightness_ramp_unit.sv
sim/tb_velocity_brightness_ramp_unit.sv
